// File: rtl/ncs_pkg.sv
// shared types, codes and helpers for the nested comment scanner
package ncs_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_DELIM    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_LEN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_DELIM   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_LEN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_NESTING = 3'd4;

  // width of the opening-delimiter match position (at most four bytes)
  localparam int SKIP_W = 2;

  typedef enum logic [1:0] {
    ST_CLOSED   = 2'd0,
    ST_NO_OPEN  = 2'd1,
    ST_UNTERM   = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ENT_START,
    ENT_BODY,
    ENT_NOOPEN
  } entry_kind_t;

  // one queue entry from front to engine
  typedef struct packed {
    entry_kind_t kind;
    logic [7:0]  data;
    logic        last;
  } entry_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] length;
  } result_t;

  // lengths here are already the effective ones
  typedef struct packed {
    logic [31:0] open_delim;
    logic [2:0]  open_len;
    logic [31:0] close_delim;
    logic [2:0]  close_len;
    logic        allow_nesting;
  } cfg_t;

  typedef enum logic [1:0] {
    FR_OPEN,
    FR_BODY,
    FR_DROP
  } front_state_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_BODY,
    ENG_SKIP
  } eng_state_t;

  typedef enum logic [1:0] {
    TST_MISS,
    TST_HIT,
    TST_WAIT
  } test_t;

  typedef enum logic [1:0] {
    IT_NONE,
    IT_CLOSE,
    IT_OPEN,
    IT_CHAR
  } iter_t;

  // zero reads as one, anything above the cap saturates
  function automatic logic [2:0] eff_len(input logic [2:0] v, input logic [2:0] cap);
    logic [2:0] r;
    r = (v == 3'd0) ? 3'd1 : v;
    if (r > cap) r = cap;
    return r;
  endfunction

endpackage

// File: rtl/nested_comment_scanner.sv
// top level of the nested block comment scanner
// Takes one text character per request with a last mark and reports, for each text,
// whether it starts with a block comment: closed with its length (delimiters
// included), no opening delimiter, unterminated, or counter overflow. The front end
// matches the opening delimiter as characters arrive and forwards the comment body
// through a four-entry queue to the engine, which holds a lookahead window of up to
// min(DELIM_MAX,4) characters and makes one delimiter decision per cycle while the
// result queue has room (close test first, then open test when nesting is on).
// Sustained rate is one character per cycle while a comment body streams and the
// result queue has room. After a text's last character the window drains, at most
// one decision per window character, and a comment still open is then reported
// unterminated; the front keeps accepting into the queue meanwhile. With an idle
// engine the result for a character that settles the opener passes through the
// character queue and is pushed when the engine pops that entry; one decided by a
// body character also waits for the window decisions before it, the most when the
// last character leaves a full window to drain. A busy engine or a full result queue
// delays either. Configuration writes are taken every cycle (cfg_ready is always
// high) and apply to the next comparison; indexes beyond the register list are ignored.
module nested_comment_scanner import ncs_pkg::*; #(
  parameter int DELIM_MAX  = 4,
  parameter int LEN_BITS   = 16,
  parameter int DEPTH_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // character requests
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [7:0]           in_ch,
  input  logic                 in_last,
  // result requests
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [1:0]           out_status,
  output logic [15:0]          out_length,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  // window size: delimiters are at most four bytes wide
  localparam int WIN = (DELIM_MAX < 4) ? DELIM_MAX : 4;

  logic [31:0] open_delim_r, close_delim_r;
  logic [2:0]  open_len_r, close_len_r;
  logic        allow_nesting_r;
  cfg_t        cfg;

  logic        in_acc;
  logic        fr_push;
  entry_t      fr_entry;
  logic        q_full, q_empty, q_pop;
  logic [$bits(entry_t)-1:0] q_rd_bits;
  entry_t      q_head;

  logic        res_push, res_full;
  result_t     res_data, res_out;
  logic [$bits(result_t)-1:0] res_rd_bits;

  // configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_delim_r    <= 32'd10799;
      open_len_r      <= 3'd2;
      close_delim_r   <= 32'd12074;
      close_len_r     <= 3'd2;
      allow_nesting_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OPEN_DELIM:    open_delim_r    <= cfg_data;
        CFG_OPEN_LEN:      open_len_r      <= cfg_data[2:0];
        CFG_CLOSE_DELIM:   close_delim_r   <= cfg_data;
        CFG_CLOSE_LEN:     close_len_r     <= cfg_data[2:0];
        CFG_ALLOW_NESTING: allow_nesting_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // effective lengths: zero counts as one, saturate at the window size
  assign cfg.open_delim    = open_delim_r;
  assign cfg.open_len      = eff_len(open_len_r, 3'(WIN));
  assign cfg.close_delim   = close_delim_r;
  assign cfg.close_len     = eff_len(close_len_r, 3'(WIN));
  assign cfg.allow_nesting = allow_nesting_r;

  // input side: accept whenever the classify queue has room
  assign in_full = q_full;
  assign in_acc  = in_push && !in_full;

  ncs_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .acc   (in_acc),
    .ch    (in_ch),
    .last  (in_last),
    .push  (fr_push),
    .entry (fr_entry)
  );

  // queue between front and engine
  ncs_fifo #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (4)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fr_push),
    .wr_data (fr_entry),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_bits),
    .empty   (q_empty)
  );

  assign q_head = entry_t'(q_rd_bits);

  ncs_engine #(
    .WIN        (WIN),
    .LEN_BITS   (LEN_BITS),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .q_valid  (!q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_data (res_data)
  );

  // result queue parts the engine from the consumer
  ncs_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_data),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (res_rd_bits),
    .empty   (out_empty)
  );

  assign res_out    = result_t'(res_rd_bits);
  assign out_status = res_out.status;
  assign out_length = res_out.length;

endmodule

// File: rtl/ncs_fifo.sv
// small register queue used between front and engine and on the result side
module ncs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/ncs_front.sv
// front end: matches the opening delimiter and classifies each character
module ncs_front import ncs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       acc,
  input  logic [7:0] ch,
  input  logic       last,
  output logic       push,
  output entry_t     entry
);

  front_state_t      state_r, state_nxt;
  logic [SKIP_W-1:0] skip_r, skip_nxt;
  logic [7:0]        exp_byte;
  logic              byte_hit;
  logic              open_done;

  assign exp_byte  = cfg.open_delim[{skip_r, 3'b000} +: 8];
  assign byte_hit  = ({1'b0, skip_r} < cfg.open_len) && (ch == exp_byte);
  assign open_done = byte_hit && (({1'b0, skip_r} + 3'd1) >= cfg.open_len);

  always_comb begin
    state_nxt = state_r;
    skip_nxt  = skip_r;
    unique case (state_r)
      FR_OPEN: begin
        if (acc) begin
          if (last || !byte_hit || open_done) begin
            skip_nxt = '0;
          end else begin
            skip_nxt = skip_r + SKIP_W'(1);
          end
          if (last) begin
            state_nxt = FR_OPEN;
          end else if (open_done) begin
            state_nxt = FR_BODY;
          end else if (!byte_hit) begin
            state_nxt = FR_DROP;
          end
        end
      end
      FR_BODY, FR_DROP: begin
        skip_nxt = '0;
        if (acc && last) begin
          state_nxt = FR_OPEN;
        end
      end
      default: begin
        state_nxt = FR_OPEN;
        skip_nxt  = '0;
      end
    endcase
  end

  always_comb begin
    push       = 1'b0;
    entry.kind = ENT_BODY;
    entry.data = ch;
    entry.last = last;
    unique case (state_r)
      FR_OPEN: begin
        if (acc && open_done) begin
          push       = 1'b1;
          entry.kind = ENT_START;
          entry.data = {5'd0, cfg.open_len};
        end else if (acc && (!byte_hit || last)) begin
          push       = 1'b1;
          entry.kind = ENT_NOOPEN;
        end
      end
      FR_BODY: begin
        push = acc;
      end
      FR_DROP: begin
        push = 1'b0;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_OPEN;
      skip_r  <= '0;
    end else begin
      state_r <= state_nxt;
      skip_r  <= skip_nxt;
    end
  end

endmodule

// File: rtl/ncs_engine.sv
// back end: lookahead window, delimiter decisions, depth and length counters
module ncs_engine import ncs_pkg::*; #(
  parameter int WIN        = 4,
  parameter int LEN_BITS   = 16,
  parameter int DEPTH_BITS = 8
) (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    q_valid,
  input  entry_t  q_head,
  output logic    q_pop,
  input  logic    res_full,
  output logic    res_push,
  output result_t res_data
);

  localparam int FILL_W = $clog2(WIN + 1);

  eng_state_t                state_r, state_nxt;
  logic [WIN-1:0][7:0]       win_r, win_nxt, win_mid;
  logic [FILL_W-1:0]         fill_r, fill_nxt, fill_mid;
  logic                      fin_r, fin_nxt;
  logic [LEN_BITS-1:0]       consumed_r, consumed_nxt;
  logic [DEPTH_BITS-1:0]     depth_r, depth_nxt;

  test_t                     close_res, open_res;
  iter_t                     iter;
  logic [2:0]                drop;
  logic [LEN_BITS:0]         sum;
  logic                      ovf;
  logic                      advance;
  logic                      body_emit;
  status_t                   body_status;

  // first differing or missing byte decides; missing means wait unless text ended
  function automatic test_t win_test(input logic [31:0] delim, input logic [2:0] len,
                                     input logic [WIN-1:0][7:0] win,
                                     input logic [FILL_W-1:0] fill, input logic fin);
    test_t r;
    logic  found;
    r     = TST_HIT;
    found = 1'b0;
    for (int i = 0; i < WIN; i++) begin
      if (!found && (3'(i) < len)) begin
        if (3'(i) >= 3'(fill)) begin
          r     = fin ? TST_MISS : TST_WAIT;
          found = 1'b1;
        end else if (win[i] != delim[8*i +: 8]) begin
          r     = TST_MISS;
          found = 1'b1;
        end
      end
    end
    return r;
  endfunction

  assign advance = !res_full;

  // decision for the current window
  always_comb begin
    close_res = win_test(cfg.close_delim, cfg.close_len, win_r, fill_r, fin_r);
    open_res  = win_test(cfg.open_delim, cfg.open_len, win_r, fill_r, fin_r);
    iter      = IT_NONE;
    if (fill_r != '0) begin
      if (close_res == TST_HIT) begin
        iter = IT_CLOSE;
      end else if (close_res == TST_MISS) begin
        if (!cfg.allow_nesting) begin
          iter = IT_CHAR;
        end else if (open_res == TST_HIT) begin
          iter = IT_OPEN;
        end else if (open_res == TST_MISS) begin
          iter = IT_CHAR;
        end
      end
    end
    case (iter)
      IT_CLOSE: drop = cfg.close_len;
      IT_OPEN:  drop = cfg.open_len;
      IT_CHAR:  drop = 3'd1;
      default:  drop = 3'd0;
    endcase
    sum = {1'b0, consumed_r} + (LEN_BITS + 1)'(drop);
    ovf = sum[LEN_BITS] || ((iter == IT_OPEN) && (&depth_r));
    body_emit   = 1'b0;
    body_status = ST_CLOSED;
    if ((iter != IT_NONE) && ovf) begin
      body_emit   = 1'b1;
      body_status = ST_OVERFLOW;
    end else if ((iter == IT_CLOSE) && (depth_r == DEPTH_BITS'(1))) begin
      body_emit   = 1'b1;
      body_status = ST_CLOSED;
    end else if ((iter == IT_NONE) && fin_r && (fill_r == '0)) begin
      body_emit   = 1'b1;
      body_status = ST_UNTERM;
    end
  end

  // window after dropping the matched characters
  always_comb begin
    win_mid = win_r;
    for (int s = 1; s < WIN; s++) begin
      for (int j = 0; j < WIN - s; j++) begin
        if (drop == 3'(s)) begin
          win_mid[j] = win_r[j + s];
        end
      end
    end
    fill_mid = (drop >= 3'(fill_r)) ? '0 : FILL_W'(3'(fill_r) - drop);
  end

  always_comb begin
    state_nxt = state_r;
    if (advance) begin
      unique case (state_r)
        ENG_IDLE: begin
          if (q_valid && (q_head.kind == ENT_START) && !q_head.last) begin
            state_nxt = ENG_BODY;
          end
        end
        ENG_BODY: begin
          if (body_emit) begin
            state_nxt = fin_r ? ENG_IDLE : ENG_SKIP;
          end
        end
        ENG_SKIP: begin
          if (q_valid && q_head.last) begin
            state_nxt = ENG_IDLE;
          end
        end
        default: begin
          state_nxt = ENG_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    q_pop           = 1'b0;
    res_push        = 1'b0;
    res_data.status = ST_CLOSED;
    res_data.length = '0;
    win_nxt         = win_r;
    fill_nxt        = fill_r;
    fin_nxt         = fin_r;
    consumed_nxt    = consumed_r;
    depth_nxt       = depth_r;
    if (advance) begin
      unique case (state_r)
        ENG_IDLE: begin
          if (q_valid) begin
            q_pop = 1'b1;
            case (q_head.kind)
              ENT_START: begin
                consumed_nxt = LEN_BITS'(q_head.data[2:0]);
                depth_nxt    = DEPTH_BITS'(1);
                fill_nxt     = '0;
                fin_nxt      = 1'b0;
                if (q_head.last) begin
                  res_push        = 1'b1;
                  res_data.status = ST_UNTERM;
                end
              end
              ENT_NOOPEN: begin
                res_push        = 1'b1;
                res_data.status = ST_NO_OPEN;
              end
              default: begin
              end
            endcase
          end
        end
        ENG_BODY: begin
          if (body_emit) begin
            res_push        = 1'b1;
            res_data.status = body_status;
            if (body_status == ST_CLOSED) begin
              res_data.length = 16'(sum[LEN_BITS-1:0]);
            end
            fin_nxt = 1'b0;
          end else begin
            if (iter != IT_NONE) begin
              consumed_nxt = sum[LEN_BITS-1:0];
              if (iter == IT_CLOSE) begin
                depth_nxt = depth_r - DEPTH_BITS'(1);
              end else if (iter == IT_OPEN) begin
                depth_nxt = depth_r + DEPTH_BITS'(1);
              end
            end
            win_nxt  = win_mid;
            fill_nxt = fill_mid;
            if (!fin_r && q_valid) begin
              q_pop = 1'b1;
              for (int j = 0; j < WIN; j++) begin
                if (FILL_W'(j) == fill_mid) begin
                  win_nxt[j] = q_head.data;
                end
              end
              fill_nxt = fill_mid + FILL_W'(1);
              fin_nxt  = q_head.last;
            end
          end
        end
        ENG_SKIP: begin
          q_pop = q_valid;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    win_r      <= win_nxt;
    consumed_r <= consumed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ENG_IDLE;
      fill_r  <= '0;
      fin_r   <= 1'b0;
      depth_r <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      fin_r   <= fin_nxt;
      depth_r <= depth_nxt;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(WIN))
    else $error("lookahead fill above window size");

  a_no_pop_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ENG_BODY && fin_r) |-> !q_pop)
    else $error("engine took a character past the end of its text");

  a_body_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ENG_BODY) |-> (depth_r != '0))
    else $error("scanning body with zero depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  a_idle_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ENG_BODY && fin_r && body_emit && advance) |=> (state_r == ENG_IDLE))
    else $error("engine did not return to idle after end of text");

endmodule

// File: tb/sv/scan_check_pkg.sv
// scoreboard class that predicts and checks the comment scanner's results
package scan_check_pkg;
  import ncs_pkg::*;

  localparam int unsigned WINDOW_MAX = 4;
  localparam int unsigned LEN_MAX    = 65535;
  localparam int unsigned DEPTH_MAX  = 255;

  typedef enum logic [1:0] {
    AT_OPENER,
    IN_BODY,
    TEXT_DONE
  } text_phase_t;

  class scan_checker;
    // register copy
    logic [31:0] open_delim;
    logic [2:0]  open_len;
    logic [31:0] close_delim;
    logic [2:0]  close_len;
    logic        allow_nesting;

    // per-text scan state
    logic [7:0]  window [WINDOW_MAX];
    int unsigned fill;
    int unsigned depth;
    int unsigned consumed;
    int unsigned skip;
    text_phase_t phase;

    result_t     pending_results [$];
    int unsigned errors;
    int unsigned chars;
    int unsigned texts;
    int unsigned results;
    int unsigned by_status [4];

    function new();
      open_delim    = 32'h0000_2a2f;
      open_len      = 3'd2;
      close_delim   = 32'h0000_2f2a;
      close_len     = 3'd2;
      allow_nesting = 1'b0;
      errors  = 0;
      chars   = 0;
      texts   = 0;
      results = 0;
      foreach (by_status[i]) by_status[i] = 0;
      clear_text();
    endfunction

    function void clear_text();
      foreach (window[i]) window[i] = 8'h00;
      fill     = 0;
      depth    = 0;
      consumed = 0;
      skip     = 0;
      phase    = AT_OPENER;
    endfunction

    function int unsigned clip_len(logic [2:0] v);
      int unsigned r;
      r = (v == 3'd0) ? 1 : v;
      if (r > WINDOW_MAX) r = WINDOW_MAX;
      return r;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        CFG_OPEN_DELIM:    open_delim    = data;
        CFG_OPEN_LEN:      open_len      = data[2:0];
        CFG_CLOSE_DELIM:   close_delim   = data;
        CFG_CLOSE_LEN:     close_len     = data[2:0];
        CFG_ALLOW_NESTING: allow_nesting = data[0];
        default: ;
      endcase
    endfunction

    function test_t window_test(logic [31:0] word, int unsigned len, bit fin);
      for (int i = 0; i < len; i++) begin
        if (i >= fill) return fin ? TST_MISS : TST_WAIT;
        if (window[i] != word[8*i +: 8]) return TST_MISS;
      end
      return TST_HIT;
    endfunction

    function void window_drop(int unsigned k);
      if (k >= fill) begin
        fill = 0;
      end else begin
        for (int i = 0; i + k < fill; i++) window[i] = window[i+k];
        fill = fill - k;
      end
    endfunction

    function void give(status_t st, int unsigned len);
      result_t r;
      r.status = st;
      r.length = len[15:0];
      pending_results.push_back(r);
      phase = TEXT_DONE;
    endfunction

    // advance the scan by one accepted character
    function void scan_char(logic [7:0] ch, bit fin);
      int unsigned olen;
      int unsigned clen;
      test_t       t;
      olen = clip_len(open_len);
      clen = clip_len(close_len);
      chars++;
      if (phase == IN_BODY) begin
        if (fill < WINDOW_MAX) begin
          window[fill] = ch;
          fill++;
        end
      end else if (phase == AT_OPENER) begin
        if (skip < olen && ch == open_delim[8*skip +: 8]) begin
          skip++;
          if (skip >= olen) begin
            phase    = IN_BODY;
            depth    = 1;
            consumed = skip;
            fill     = 0;
          end
        end else begin
          give(ST_NO_OPEN, 0);
        end
      end

      while (phase == IN_BODY && fill > 0) begin
        t = window_test(close_delim, clen, fin);
        if (t == TST_WAIT) break;
        if (t == TST_HIT) begin
          if (consumed + clen > LEN_MAX) begin
            give(ST_OVERFLOW, 0);
            break;
          end
          consumed += clen;
          window_drop(clen);
          depth--;
          if (depth == 0) begin
            give(ST_CLOSED, consumed);
            break;
          end
          continue;
        end
        if (allow_nesting) begin
          t = window_test(open_delim, olen, fin);
          if (t == TST_WAIT) break;
          if (t == TST_HIT) begin
            if (depth >= DEPTH_MAX || consumed + olen > LEN_MAX) begin
              give(ST_OVERFLOW, 0);
              break;
            end
            depth++;
            consumed += olen;
            window_drop(olen);
            continue;
          end
        end
        if (consumed + 1 > LEN_MAX) begin
          give(ST_OVERFLOW, 0);
          break;
        end
        consumed++;
        window_drop(1);
      end

      if (fin) begin
        if (phase == AT_OPENER) give(ST_NO_OPEN, 0);
        else if (phase == IN_BODY) give(ST_UNTERM, 0);
        clear_text();
        texts++;
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("mismatch: %s", msg);
    endtask

    task check_result(logic [1:0] status, logic [15:0] length);
      result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result status %0d length %0d", status, length));
        return;
      end
      want = pending_results.pop_front();
      results++;
      by_status[want.status]++;
      if (status !== want.status)
        report($sformatf("result %0d status %0d, want %s", results, status,
                         want.status.name()));
      if (length !== want.length)
        report($sformatf("result %0d length %0d, want %0d", results, length, want.length));
    endtask

    function int unsigned pending();
      return pending_results.size();
    endfunction
  endclass

endpackage

// File: tb/sv/testbench.sv
// top-level testbench for the nested comment scanner
module testbench;
  import ncs_pkg::*;
  import scan_check_pkg::*;

  typedef logic [7:0] char_q_t [$];

  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int unsigned QUIET_CYCLES = 16;   // window drain plus output latency, with margin
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned RANDOM_CHARS = 400;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_FIRST = 3'd5;

  logic                 clk;
  logic                 rst_n;
  logic                 in_push;
  logic                 in_full;
  logic [7:0]           in_ch;
  logic                 in_last;
  logic                 out_empty;
  logic                 out_pop;
  logic [1:0]           out_status;
  logic [15:0]          out_length;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  scan_checker sb = new();

  // calm: neither side idles; hold_request: ask the receiver for a long hold-off
  bit          calm;
  bit          hold_request;
  int unsigned full_stalls;
  int unsigned settings;

  nested_comment_scanner u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_ch      (in_ch),
    .in_last    (in_last),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_status (out_status),
    .out_length (out_length),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // safety net against a hung handshake
  initial begin
    #(LIMIT_CYCLES * 4);
    $display("TEST FAILED");
    $finish;
  end

  // sample both handshakes at the rising edge, before the block updates
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) sb.check_result(out_status, out_length);
    if (rst_n && in_push && in_full) full_stalls++;
  end

  // result side: random pops, plus a counted hold-off when asked
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    out_pop   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= calm || ($urandom_range(99) >= 26);
      end
    end
  end

  // one character request; called and returns at a falling edge
  task automatic push_char(logic [7:0] c, logic l);
    while (!calm && $urandom_range(99) < 26) begin
      in_push <= 1'b0;
      in_ch   <= 8'($urandom_range(1, 255));
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_ch   <= c;
    in_last <= l;
    do @(posedge clk); while (in_full);
    sb.scan_char(c, l);
    @(negedge clk);
  endtask

  task automatic send_text(char_q_t txt);
    foreach (txt[i]) push_char(txt[i], i == txt.size() - 1);
  endtask

  task automatic send_string(string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
  endtask

  // sender pause: nothing offered until every expected result is back
  task automatic wait_drained();
    in_push <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    // a text can leave ignored characters in flight after its result
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    @(negedge clk);
  endtask

  // full register setting, written only once the block has gone quiet
  task automatic apply_setting(logic [31:0] od, logic [2:0] ol, logic [31:0] cd,
                               logic [2:0] cl, logic nest);
    logic [31:0] w;
    wait_drained();
    write_reg(CFG_OPEN_DELIM, od);
    w = $urandom;
    w[2:0] = ol;
    write_reg(CFG_OPEN_LEN, w);
    write_reg(CFG_CLOSE_DELIM, cd);
    w = $urandom;
    w[2:0] = cl;
    write_reg(CFG_CLOSE_LEN, w);
    w = $urandom;
    w[0] = nest;
    write_reg(CFG_ALLOW_NESTING, w);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // delimiter bytes lean on a small punctuation set so texts hit them often
  function automatic logic [7:0] delim_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return 8'($urandom_range(33, 47));
    if (r < 85) return 8'($urandom_range(1, 255));
    if (r < 93) return 8'hff;
    return 8'h00;
  endfunction

  // text characters are never zero
  function automatic logic [7:0] nonzero(logic [7:0] b);
    return (b == 8'h00) ? 8'($urandom_range(1, 255)) : b;
  endfunction

  function automatic logic [7:0] body_byte(int unsigned olen, int unsigned clen);
    int unsigned r;
    int unsigned pos;
    r = $urandom_range(99);
    if (r < 35) begin
      pos = $urandom_range(olen - 1);
      return nonzero(sb.open_delim[8*pos +: 8]);
    end
    if (r < 70) begin
      pos = $urandom_range(clen - 1);
      return nonzero(sb.close_delim[8*pos +: 8]);
    end
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic append_delim(ref char_q_t txt, input logic [31:0] word,
                              input int unsigned len);
    for (int i = 0; i < len; i++) txt.push_back(nonzero(word[8*i +: 8]));
  endtask

  // mostly well-formed comments with random bodies; the rest broken or noise
  task automatic send_random_text(bit noise_only);
    char_q_t     txt;
    int unsigned olen;
    int unsigned clen;
    int unsigned kind;
    int unsigned opens;
    int unsigned k;
    olen = sb.clip_len(sb.open_len);
    clen = sb.clip_len(sb.close_len);
    kind = noise_only ? 99 : $urandom_range(99);
    if (kind < 70) begin
      append_delim(txt, sb.open_delim, olen);
      opens = 1;
      repeat ($urandom_range(0, 12)) begin
        k = $urandom_range(99);
        if (k < 15) begin
          append_delim(txt, sb.open_delim, olen);
          opens++;
        end else if (k < 30) begin
          append_delim(txt, sb.close_delim, clen);
        end else begin
          txt.push_back(body_byte(olen, clen));
        end
      end
      if ($urandom_range(99) < 85) repeat (opens) append_delim(txt, sb.close_delim, clen);
      repeat ($urandom_range(0, 3)) txt.push_back(body_byte(olen, clen));
    end else if (kind < 85) begin
      // opener cut short
      k = $urandom_range(olen - 1);
      for (int i = 0; i < k; i++) txt.push_back(nonzero(sb.open_delim[8*i +: 8]));
      repeat ($urandom_range(0, 4)) txt.push_back(body_byte(olen, clen));
    end else begin
      repeat ($urandom_range(1, noise_only ? 2 : 8)) txt.push_back(8'($urandom_range(1, 255)));
    end
    if (txt.size() == 0) txt.push_back(8'($urandom_range(1, 255)));
    send_text(txt);
  endtask

  task automatic random_setting(int unsigned pick);
    logic [31:0] od;
    logic [31:0] cd;
    logic [2:0]  ol;
    logic [2:0]  cl;
    for (int i = 0; i < 4; i++) begin
      od[8*i +: 8] = delim_byte();
      cd[8*i +: 8] = delim_byte();
    end
    if ($urandom_range(5) == 0) od = $urandom;
    if ($urandom_range(5) == 0) cd = $urandom;
    // first settings pin the length extremes, including the saturating codes
    case (pick)
      0: begin ol = 3'd1; cl = 3'd1; end
      1: begin ol = 3'd4; cl = 3'd4; end
      2: begin ol = 3'd0; cl = 3'd7; end
      3: begin ol = 3'd7; cl = 3'd0; end
      default: begin
        ol = 3'($urandom_range(7));
        cl = 3'($urandom_range(7));
      end
    endcase
    apply_setting(od, ol, cd, cl, 1'($urandom_range(1)));
  endtask

  initial begin : stimulus
    char_q_t     txt;
    int unsigned random_start;
    int unsigned round;
    rst_n        = 1'b0;
    in_push      = 1'b0;
    in_ch        = 8'h01;
    in_last      = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_OPEN_DELIM;
    cfg_data     = 32'h0;
    calm         = 1'b0;
    hold_request = 1'b0;
    full_stalls  = 0;
    settings     = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // writes past the register list must change nothing
    for (int i = CFG_UNUSED_FIRST; i < 2**CFG_IDX_W; i++) write_reg(CFG_IDX_W'(i), $urandom);
    cfg_valid <= 1'b0;
    @(negedge clk);

    // reset delimiters, no nesting: closed, no opener, short opener,
    // last mark inside an incomplete closer, inner opener ignored
    send_string("/**/");
    send_string("a");
    send_string("/");
    send_string("/*x*");
    send_string("/*/**/*/");

    // same text with nesting on closes only at the end
    apply_setting(32'h0000_2a2f, 3'd2, 32'h0000_2f2a, 3'd2, 1'b1);
    send_string("/*/**/*/");

    // depth climbs to the counter limit and one opener more overflows it
    apply_setting(32'h0000_0028, 3'd1, 32'h0000_0029, 3'd1, 1'b1);
    txt.delete();
    repeat (DEPTH_MAX + 3) txt.push_back(8'h28);
    send_text(txt);

    // random phases, each under a fresh register setting
    random_start = sb.chars;
    round = 0;
    while (round < 4 || sb.chars - random_start < RANDOM_CHARS) begin
      random_setting(round);
      calm = (round == 2);
      if (round == 3) begin
        // hold the results back while short texts pile up and fill the block
        hold_request = 1'b1;
        repeat (100) send_random_text(1'b1);
      end else begin
        repeat (8) begin
          send_random_text(1'b0);
          if ($urandom_range(99) < 6) wait_drained();
        end
      end
      round++;
    end
    calm = 1'b0;

    wait_drained();
    repeat (QUIET_CYCLES) @(negedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));

    $display("covered %0d texts, %0d characters, %0d register settings, %0d full-input cycles",
             sb.texts, sb.chars, settings, full_stalls);
    $display("results: %0d closed, %0d no opener, %0d unterminated, %0d overflow; %0d errors",
             sb.by_status[ST_CLOSED], sb.by_status[ST_NO_OPEN], sb.by_status[ST_UNTERM],
             sb.by_status[ST_OVERFLOW], sb.errors);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/ncs_pkg.sv
rtl/ncs_fifo.sv
rtl/ncs_front.sv
rtl/ncs_engine.sv
rtl/nested_comment_scanner.sv
tb/sv/scan_check_pkg.sv
tb/sv/testbench.sv
